// ===== hw/rtl/cpa_pkg.sv =====
// ============================================================================
// Contact pair averager package
// Item types, request codes, sequencer states and shared constants.
// ============================================================================
package cpa_pkg;

    localparam int SUM_W  = 48;
    localparam int N_COMP = 9;
    localparam int CNT_W  = 16;
    localparam int DATA_W = CNT_W + N_COMP * SUM_W;
    localparam int DIVD_W = 48;
    localparam int DIVS_W = 32;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [31:0]      UNIT_ONE  = 32'h0001_0000;
    localparam logic [31:0]      NORM_MIN  = 32'h4000_0000;
    localparam logic [63:0]      TOL_LO    = 64'd9801 << 32;
    localparam logic [63:0]      TOL_HI    = 64'd10201 << 32;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [63:0]        entity_pair;
        logic [4:0]         slot_index;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] point_a_x;
        logic signed [31:0] point_a_y;
        logic signed [31:0] point_a_z;
        logic signed [31:0] point_b_x;
        logic signed [31:0] point_b_y;
        logic signed [31:0] point_b_z;
    } t_in_item;

    typedef struct packed {
        logic               accepted;
        logic [63:0]        pair_out;
        logic signed [31:0] avg_normal_x;
        logic signed [31:0] avg_normal_y;
        logic signed [31:0] avg_normal_z;
        logic signed [31:0] avg_point_a_x;
        logic signed [31:0] avg_point_a_y;
        logic signed [31:0] avg_point_a_z;
        logic signed [31:0] avg_point_b_x;
        logic signed [31:0] avg_point_b_y;
        logic signed [31:0] avg_point_b_z;
        logic               used_fallback;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SEARCH,
        S_SCMP,
        S_ADD_WR,
        S_NEW,
        S_RD_ISSUE,
        S_RD_LOAD,
        S_DIV_START,
        S_DIV_WAIT,
        S_NORM_INIT,
        S_NORM_SHIFT,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQRT,
        S_UDIV_START,
        S_UDIV_WAIT,
        S_CHECK,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/contact_pair_averager_top.sv =====
// ============================================================================
// Contact pair averager
// Slot table keyed by entity pair that sums contact normals and points and
// returns renormalized averages on request.
// ============================================================================
// A clear is taken at once; an add compares the stored keys slot by slot, then
// updates the matching slot or writes a new one; a read runs twelve divider passes
// (start, 48 steps, done), a 32-step square root and up to 30 normalizing shifts,
// and skips the root and the unit divides for a zero normal.
// Throughput: one item at a time; the next item is taken once the result is
// in the output register. Reset empties the table and clears all handshakes.
module contact_pair_averager_top #(
    parameter int MAX_PAIRS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cpa_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cpa_pkg::t_out_item o_out_item
);
    import cpa_pkg::*;

    localparam int IW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int CW = $clog2(MAX_PAIRS + 1);

    // Sequencer and table state.
    t_state r_state, n_state;
    logic [CW-1:0] r_used;
    logic [CW-1:0] r_slot;
    t_in_item      r_in;
    logic          r_swap;
    logic          r_acc;
    logic          r_isread;
    logic          r_fb;
    logic          r_phase;
    logic [3:0]    r_k;

    // Read datapath registers. The averaged normal can reach +2^31 after
    // swapped adds, so the averages carry one extra sign bit.
    logic [63:0]              r_pair;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [SUM_W-1:0]  r_sums [N_COMP];
    logic signed [32:0]       r_res  [N_COMP];
    logic signed [32:0]       r_s    [3];
    logic signed [31:0]       r_u    [3];
    logic [31:0]              r_m;
    logic [63:0]              r_prod;
    logic [63:0]              r_len2;
    logic [63:0]              r_root;
    logic [63:0]              r_bit;

    // Output register.
    logic      r_ovalid;
    t_out_item r_out;
    t_out_item n_out;

    // Memory ports.
    logic              key_we;
    logic              data_we;
    logic [63:0]       key_rdata;
    logic [DATA_W-1:0] data_rdata;
    logic [DATA_W-1:0] data_wdata;
    logic [IW-1:0]     ram_addr;

    // Divider port.
    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVS_W-1:0] div_divisor;
    logic              div_busy;
    logic              div_done;
    logic [DIVD_W-1:0] div_quot;

    logic              in_fire;
    logic              out_free;
    logic              key_direct;
    logic              key_swapped;
    logic [CNT_W-1:0]  old_cnt;
    logic              cnt_full;
    logic [5:0]        idx_ext;
    logic              idx_ok;
    logic signed [SUM_W-1:0] terms [N_COMP];
    logic [CNT_W-1:0]  cnt_eff;
    logic signed [SUM_W-1:0] sum_k;
    logic [SUM_W-1:0]  sum_mag;
    logic [31:0]       res_mag [3];
    logic [31:0]       m_init;
    logic [31:0]       mul_op;
    logic [63:0]       sq_sum;
    logic [63:0]       tol_prod;
    logic              tol_ok;
    logic [31:0]       s_mag_k;
    logic              quot_neg;

    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign ram_addr   = r_slot[IW-1:0];

    // Both entity orders are compared against the stored key; the direct
    // order wins when a slot matches both ways.
    assign key_direct  = (key_rdata[63:32] == r_in.entity_pair[63:32]) &&
                         (key_rdata[31:0]  == r_in.entity_pair[31:0]);
    assign key_swapped = (key_rdata[63:32] == r_in.entity_pair[31:0]) &&
                         (key_rdata[31:0]  == r_in.entity_pair[63:32]);

    assign old_cnt  = data_rdata[DATA_W-1 -: CNT_W];
    assign cnt_full = (old_cnt == COUNT_MAX);

    assign idx_ext = 6'(i_in_item.slot_index);
    assign idx_ok  = (idx_ext < 6'(r_used)) && (idx_ext < 6'(MAX_PAIRS));

    cpa_ram #(.WIDTH(64), .DEPTH(MAX_PAIRS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (ram_addr),
        .i_wdata (r_in.entity_pair),
        .i_raddr (ram_addr),
        .o_rdata (key_rdata)
    );

    // Each data word holds the slot count above nine 48-bit sums:
    // normal x,y,z, point A x,y,z, point B x,y,z from the low end.
    cpa_ram #(.WIDTH(DATA_W), .DEPTH(MAX_PAIRS)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (ram_addr),
        .i_wdata (data_wdata),
        .i_raddr (ram_addr),
        .o_rdata (data_rdata)
    );

    cpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Terms added to the sums. A swapped pair negates the normal and
    // exchanges the two points so the slot keeps its stored orientation.
    always_comb begin
        if (r_swap) begin
            terms[0] = -SUM_W'(r_in.normal_x);
            terms[1] = -SUM_W'(r_in.normal_y);
            terms[2] = -SUM_W'(r_in.normal_z);
            terms[3] = SUM_W'(r_in.point_b_x);
            terms[4] = SUM_W'(r_in.point_b_y);
            terms[5] = SUM_W'(r_in.point_b_z);
            terms[6] = SUM_W'(r_in.point_a_x);
            terms[7] = SUM_W'(r_in.point_a_y);
            terms[8] = SUM_W'(r_in.point_a_z);
        end else begin
            terms[0] = SUM_W'(r_in.normal_x);
            terms[1] = SUM_W'(r_in.normal_y);
            terms[2] = SUM_W'(r_in.normal_z);
            terms[3] = SUM_W'(r_in.point_a_x);
            terms[4] = SUM_W'(r_in.point_a_y);
            terms[5] = SUM_W'(r_in.point_a_z);
            terms[6] = SUM_W'(r_in.point_b_x);
            terms[7] = SUM_W'(r_in.point_b_y);
            terms[8] = SUM_W'(r_in.point_b_z);
        end
    end

    // Divider operands: rounding to nearest is done by adding half the
    // divisor to the magnitude before the divide.
    assign cnt_eff  = (r_cnt == '0) ? CNT_W'(1) : r_cnt;
    assign sum_k    = r_sums[r_k];
    assign sum_mag  = sum_k[SUM_W-1] ? SUM_W'(-sum_k) : SUM_W'(sum_k);
    assign s_mag_k  = r_s[r_k[1:0]][32] ? 32'(-r_s[r_k[1:0]]) : 32'(r_s[r_k[1:0]]);
    assign quot_neg = (r_state == S_DIV_WAIT) ? sum_k[SUM_W-1] : r_s[r_k[1:0]][32];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            res_mag[i] = r_res[i][32] ? 32'(-r_res[i]) : 32'(r_res[i]);
        end
        m_init = res_mag[0];
        if (res_mag[1] > m_init) begin
            m_init = res_mag[1];
        end
        if (res_mag[2] > m_init) begin
            m_init = res_mag[2];
        end
    end

    assign mul_op   = r_phase ? (r_u[r_k[1:0]][31] ? 32'(-r_u[r_k[1:0]]) : 32'(r_u[r_k[1:0]]))
                              : s_mag_k;
    assign sq_sum   = r_root + r_bit;
    assign tol_prod = 64'(r_len2 * 64'd10000);
    assign tol_ok   = (tol_prod >= TOL_LO) && (tol_prod <= TOL_HI);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_in_item.req_type)
                        REQ_ADD:  n_state = S_SEARCH;
                        REQ_READ: n_state = idx_ok ? S_RD_ISSUE : S_DONE;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_SEARCH:     n_state = (r_slot == r_used) ? S_NEW : S_SCMP;
            S_SCMP:       n_state = (key_direct || key_swapped) ? S_ADD_WR : S_SEARCH;
            S_ADD_WR:     n_state = S_DONE;
            S_NEW:        n_state = S_DONE;
            S_RD_ISSUE:   n_state = S_RD_LOAD;
            S_RD_LOAD:    n_state = S_DIV_START;
            S_DIV_START:  n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = (r_k == 4'(N_COMP - 1)) ? S_NORM_INIT : S_DIV_START;
                end
            end
            S_NORM_INIT:  n_state = (m_init == '0) ? S_DONE : S_NORM_SHIFT;
            S_NORM_SHIFT: n_state = (r_m < NORM_MIN) ? S_NORM_SHIFT : S_SQ_MUL;
            S_SQ_MUL:     n_state = S_SQ_ACC;
            S_SQ_ACC: begin
                if (r_k != 4'd2) begin
                    n_state = S_SQ_MUL;
                end else begin
                    n_state = r_phase ? S_CHECK : S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_bit == '0) begin
                    n_state = (r_root == '0) ? S_DONE : S_UDIV_START;
                end
            end
            S_UDIV_START: n_state = S_UDIV_WAIT;
            S_UDIV_WAIT: begin
                if (div_done) begin
                    n_state = (r_k == 4'd2) ? S_SQ_MUL : S_UDIV_START;
                end
            end
            S_CHECK:      n_state = S_DONE;
            S_DONE:       n_state = out_free ? S_IDLE : S_DONE;
            default:      n_state = S_IDLE;
        endcase
    end

    // Memory and divider controls.
    always_comb begin
        key_we       = 1'b0;
        data_we      = 1'b0;
        data_wdata   = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (r_state)
            S_ADD_WR: begin
                data_we = !cnt_full;
                data_wdata[DATA_W-1 -: CNT_W] = old_cnt + 1'b1;
                for (int j = 0; j < N_COMP; j++) begin
                    data_wdata[j*SUM_W +: SUM_W] = data_rdata[j*SUM_W +: SUM_W] + terms[j];
                end
            end
            S_NEW: begin
                key_we  = (r_used < CW'(MAX_PAIRS));
                data_we = key_we;
                data_wdata[DATA_W-1 -: CNT_W] = CNT_W'(1);
                for (int j = 0; j < N_COMP; j++) begin
                    data_wdata[j*SUM_W +: SUM_W] = terms[j];
                end
            end
            S_DIV_START: begin
                div_start    = 1'b1;
                div_dividend = sum_mag + DIVD_W'(cnt_eff >> 1);
                div_divisor  = DIVS_W'(cnt_eff);
            end
            S_UDIV_START: begin
                div_start    = 1'b1;
                div_dividend = {s_mag_k, 16'h0000} + DIVD_W'(r_root[31:1]);
                div_divisor  = r_root[31:0];
            end
            default: begin
            end
        endcase
    end

    // Result item assembled from the finished request.
    always_comb begin
        n_out          = '0;
        n_out.accepted = r_acc;
        if (r_isread) begin
            n_out.pair_out      = r_pair;
            n_out.avg_point_a_x = r_res[3][31:0];
            n_out.avg_point_a_y = r_res[4][31:0];
            n_out.avg_point_a_z = r_res[5][31:0];
            n_out.avg_point_b_x = r_res[6][31:0];
            n_out.avg_point_b_y = r_res[7][31:0];
            n_out.avg_point_b_z = r_res[8][31:0];
            n_out.used_fallback = r_fb;
            if (r_fb) begin
                n_out.avg_normal_y = UNIT_ONE;
            end else begin
                n_out.avg_normal_x = r_u[0];
                n_out.avg_normal_y = r_u[1];
                n_out.avg_normal_z = r_u[2];
            end
        end
    end

    // Sequencer registers and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_in     <= i_in_item;
                        r_swap   <= 1'b0;
                        r_fb     <= 1'b0;
                        r_phase  <= 1'b0;
                        r_k      <= '0;
                        r_isread <= (i_in_item.req_type == REQ_READ) && idx_ok;
                        r_acc    <= ((i_in_item.req_type == REQ_READ) && idx_ok) ||
                                    (i_in_item.req_type == REQ_CLEAR);
                        r_slot   <= (i_in_item.req_type == REQ_READ) ?
                                    CW'(i_in_item.slot_index) : '0;
                        if (i_in_item.req_type == REQ_CLEAR) begin
                            r_used <= '0;
                        end
                    end
                end
                S_SCMP: begin
                    if (key_direct || key_swapped) begin
                        r_swap <= !key_direct;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end
                S_ADD_WR: r_acc <= !cnt_full;
                S_NEW: begin
                    if (r_used < CW'(MAX_PAIRS)) begin
                        r_used <= r_used + 1'b1;
                        r_acc  <= 1'b1;
                    end
                end
                S_RD_LOAD: begin
                    r_pair <= key_rdata;
                    r_cnt  <= old_cnt;
                    for (int j = 0; j < N_COMP; j++) begin
                        r_sums[j] <= data_rdata[j*SUM_W +: SUM_W];
                    end
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_res[r_k] <= quot_neg ? -33'(div_quot) : 33'(div_quot);
                        r_k        <= (r_k == 4'(N_COMP - 1)) ? 4'd0 : r_k + 1'b1;
                    end
                end
                S_NORM_INIT: begin
                    r_m    <= m_init;
                    r_len2 <= '0;
                    if (m_init == '0) begin
                        r_fb <= 1'b1;
                    end
                    for (int i = 0; i < 3; i++) begin
                        r_s[i] <= 33'(r_res[i]);
                    end
                end
                S_NORM_SHIFT: begin
                    if (r_m < NORM_MIN) begin
                        r_m <= r_m << 1;
                        for (int i = 0; i < 3; i++) begin
                            r_s[i] <= r_s[i] <<< 1;
                        end
                    end
                end
                S_SQ_MUL: r_prod <= 64'(mul_op) * 64'(mul_op);
                S_SQ_ACC: begin
                    r_len2 <= r_len2 + r_prod;
                    r_k    <= (r_k == 4'd2) ? 4'd0 : r_k + 1'b1;
                    r_root <= '0;
                    r_bit  <= 64'd1 << 62;
                end
                S_SQRT: begin
                    if (r_bit != '0) begin
                        if (r_len2 >= sq_sum) begin
                            r_len2 <= r_len2 - sq_sum;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end else if (r_root == '0) begin
                        r_fb <= 1'b1;
                    end
                end
                S_UDIV_WAIT: begin
                    if (div_done) begin
                        r_u[r_k[1:0]] <= quot_neg ? -32'(div_quot) : 32'(div_quot);
                        if (r_k == 4'd2) begin
                            r_k     <= '0;
                            r_phase <= 1'b1;
                            r_len2  <= '0;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_CHECK: begin
                    if (!tol_ok) begin
                        r_fb <= 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out <= n_out;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    // The table never holds more pairs than it has slots.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(MAX_PAIRS))
        else $error("slot count beyond table size");

    // A new key is only written into a free slot.
    a_key_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_we |-> (r_slot == r_used) && (r_used < CW'(MAX_PAIRS)))
        else $error("key written outside the free slot");

    // The slot count only grows by one or drops to zero on a clear.
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != $past(r_used)) |-> (r_used == $past(r_used) + 1'b1) || (r_used == '0))
        else $error("slot count jumped");

    // The divider is never restarted while a division is running.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // A clear empties the table on the next cycle.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_item.req_type == REQ_CLEAR) |=> (r_used == '0))
        else $error("clear did not empty the table");

endmodule

// ===== hw/rtl/cpa_ram.sv =====
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ============================================================================
module cpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hw/rtl/cpa_div.sv =====
// ============================================================================
// Restoring divider
// Unsigned quotient, one bit per cycle over the dividend width.
// ============================================================================
module cpa_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cpa_pkg::DIVD_W-1:0]  i_dividend,
    input  logic [cpa_pkg::DIVS_W-1:0]  i_divisor,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [cpa_pkg::DIVD_W-1:0]  o_quot
);
    import cpa_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_dvs;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [DIVS_W:0]   rem_sh;
    logic [DIVS_W+1:0] trial;

    assign rem_sh = {r_rem, o_quot[DIVD_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == STEP_W'(1));
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DIVD_W);
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                o_quot <= i_dividend;
            end else if (r_busy) begin
                if (!trial[DIVS_W+1]) begin
                    r_rem  <= trial[DIVS_W-1:0];
                    o_quot <= {o_quot[DIVD_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh[DIVS_W-1:0];
                    o_quot <= {o_quot[DIVD_W-2:0], 1'b0};
                end
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

// ===== bench/contact_pair_averager_top_tb.sv =====
// ============================================================================
// Contact pair averager testbench
// Drives add, read, clear and unused requests through the valid/ready input,
// predicts every result with an independent table model in the bench, and
// compares each result field by field under varied sender and receiver idling.
// ============================================================================
module contact_pair_averager_top_tb;

    import cpa_pkg::*;

    localparam int          TABLE_SLOTS = 20;
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;
    localparam int          CLK_HALF    = 2;
    localparam int          WATCHDOG    = 20000;
    localparam int          DRAIN_WAIT  = 800;
    localparam int          KEY_POOL    = 24;

    // Idling modes: none, sender gaps, receiver stalls, both.
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    contact_pair_averager_top #(
        .MAX_PAIRS(TABLE_SLOTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    // Pending requests waiting for the driver, and predicted results in order.
    t_in_item   request_q[$];
    t_out_item  result_q[$];
    t_idle_mode idle_mode;

    int  mismatch_count;
    int  requests_sent;
    int  results_seen;
    int  fallback_seen;
    int  refused_seen;
    int  stall_cycles;
    bit  in_taken;

    // The bench's own copy of the slot table.
    int          pair_count;
    logic [63:0] pair_key[TABLE_SLOTS];
    int          pair_hits[TABLE_SLOTS];
    longint      sum_normal[TABLE_SLOTS][3];
    longint      sum_point_a[TABLE_SLOTS][3];
    longint      sum_point_b[TABLE_SLOTS][3];

    logic [63:0] key_pool[KEY_POOL];

    // ------------------------------------------------------------------------
    // Arithmetic helpers for the averaging and renormalizing datapath.
    // ------------------------------------------------------------------------

    // Signed divide rounded to nearest, ties away from zero.
    function automatic longint div_round(longint num, longint den);
        longint a;
        longint q;
        a = (num < 0) ? -num : num;
        q = (a + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Scales the averaged normal to unit length in Q16.16. Returns 1 when the
    // length of the result is within one percent of one.
    function automatic bit unit_normal(input longint avg[3], output longint unit[3]);
        longint          s[3];
        longint unsigned m;
        longint unsigned len2;
        longint unsigned r;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            s[i] = avg[i];
            if (magnitude(s[i]) > m) m = magnitude(s[i]);
            unit[i] = 0;
        end
        if (m == 0) return 1'b0;
        while (m < (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) s[i] = s[i] * 2;
            m = m * 2;
        end
        len2 = 0;
        for (int i = 0; i < 3; i++) len2 += magnitude(s[i]) * magnitude(s[i]);
        r = floor_sqrt(len2);
        if (r == 0) return 1'b0;
        len2 = 0;
        for (int i = 0; i < 3; i++) begin
            unit[i] = div_round(s[i] * 65536, longint'(r));
            len2 += magnitude(unit[i]) * magnitude(unit[i]);
        end
        return (len2 * 10000 >= TOL_LO) && (len2 * 10000 <= TOL_HI);
    endfunction

    // ------------------------------------------------------------------------
    // Table predictor: applies one accepted request and returns its result.
    // ------------------------------------------------------------------------
    function automatic t_out_item table_apply(t_in_item req);
        t_out_item res;
        longint    nv[3];
        longint    pa[3];
        longint    pb[3];
        longint    avg[3];
        longint    unit[3];
        logic [31:0] ea;
        logic [31:0] eb;
        bit        direct;
        bit        swapped;
        bit        ok;
        int        k;
        int        c;

        res = '0;
        nv  = '{longint'(req.normal_x), longint'(req.normal_y), longint'(req.normal_z)};
        pa  = '{longint'(req.point_a_x), longint'(req.point_a_y), longint'(req.point_a_z)};
        pb  = '{longint'(req.point_b_x), longint'(req.point_b_y), longint'(req.point_b_z)};
        ea  = req.entity_pair[63:32];
        eb  = req.entity_pair[31:0];

        case (req.req_type)
            REQ_ADD: begin
                // First matching slot in either order wins.
                for (k = 0; k < pair_count; k++) begin
                    direct  = (pair_key[k][63:32] == ea) && (pair_key[k][31:0] == eb);
                    swapped = (pair_key[k][63:32] == eb) && (pair_key[k][31:0] == ea);
                    if (direct || swapped) begin
                        if (pair_hits[k] >= int'(COUNT_MAX)) return res;
                        for (int i = 0; i < 3; i++) begin
                            if (direct) begin
                                sum_normal[k][i]  += nv[i];
                                sum_point_a[k][i] += pa[i];
                                sum_point_b[k][i] += pb[i];
                            end else begin
                                sum_normal[k][i]  -= nv[i];
                                sum_point_a[k][i] += pb[i];
                                sum_point_b[k][i] += pa[i];
                            end
                        end
                        pair_hits[k]++;
                        res.accepted = 1'b1;
                        return res;
                    end
                end
                if (pair_count >= TABLE_SLOTS) return res;
                pair_key[pair_count]  = req.entity_pair;
                pair_hits[pair_count] = 1;
                for (int i = 0; i < 3; i++) begin
                    sum_normal[pair_count][i]  = nv[i];
                    sum_point_a[pair_count][i] = pa[i];
                    sum_point_b[pair_count][i] = pb[i];
                end
                pair_count++;
                res.accepted = 1'b1;
            end
            REQ_READ: begin
                k = int'(req.slot_index);
                if (k >= pair_count) return res;
                c = pair_hits[k];
                for (int i = 0; i < 3; i++) avg[i] = div_round(sum_normal[k][i], c);
                ok = unit_normal(avg, unit);
                if (!ok) unit = '{0, 65536, 0};
                res.accepted      = 1'b1;
                res.pair_out      = pair_key[k];
                res.avg_normal_x  = unit[0][31:0];
                res.avg_normal_y  = unit[1][31:0];
                res.avg_normal_z  = unit[2][31:0];
                res.avg_point_a_x = 32'(div_round(sum_point_a[k][0], c));
                res.avg_point_a_y = 32'(div_round(sum_point_a[k][1], c));
                res.avg_point_a_z = 32'(div_round(sum_point_a[k][2], c));
                res.avg_point_b_x = 32'(div_round(sum_point_b[k][0], c));
                res.avg_point_b_y = 32'(div_round(sum_point_b[k][1], c));
                res.avg_point_b_z = 32'(div_round(sum_point_b[k][2], c));
                res.used_fallback = !ok;
            end
            REQ_CLEAR: begin
                pair_count   = 0;
                res.accepted = 1'b1;
            end
            default: begin
                // An unused request code is ignored and answers with all zeros.
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request builders.
    // ------------------------------------------------------------------------
    function automatic t_in_item make_request(logic [1:0] kind, logic [63:0] key,
                                              logic [4:0] slot);
        t_in_item r;
        r.req_type    = kind;
        r.entity_pair = key;
        r.slot_index  = slot;
        r.normal_x    = $urandom;
        r.normal_y    = $urandom;
        r.normal_z    = $urandom;
        r.point_a_x   = $urandom;
        r.point_a_y   = $urandom;
        r.point_a_z   = $urandom;
        r.point_b_x   = $urandom;
        r.point_b_y   = $urandom;
        r.point_b_z   = $urandom;
        // Small normals, point A x and point B z now and then, so averages stay near real contacts.
        if ($urandom_range(0, 2) == 0) begin
            r.normal_x  = $signed($urandom_range(0, 131072)) - 65536;
            r.normal_y  = $signed($urandom_range(0, 131072)) - 65536;
            r.normal_z  = $signed($urandom_range(0, 131072)) - 65536;
            r.point_a_x = $signed($urandom_range(0, 2000000)) - 1000000;
            r.point_b_z = $signed($urandom_range(0, 2000000)) - 1000000;
        end
        return r;
    endfunction

    function automatic t_in_item make_random_request();
        int          pick;
        logic [63:0] key;
        logic [4:0]  slot;
        logic [1:0]  kind;
        pick = $urandom_range(0, 99);
        key  = key_pool[$urandom_range(0, KEY_POOL - 1)];
        if ($urandom_range(0, 2) == 0) key = {key[31:0], key[63:32]};
        if ($urandom_range(0, 19) == 0) key = {$urandom, $urandom};
        slot = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(0, TABLE_SLOTS - 1));
        if (pick < 62)      kind = REQ_ADD;
        else if (pick < 96) kind = REQ_READ;
        else if (pick < 98) kind = REQ_CLEAR;
        else                kind = REQ_UNUSED;
        return make_request(kind, key, slot);
    endfunction

    // ------------------------------------------------------------------------
    // Clock and reset. Reset is applied once, synchronously, at the start.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driver. The posedge half records accepted items and runs the predictor;
    // the negedge half presents the next item, honoring sender idling.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            result_q.push_back(table_apply(i_in_item));
            requests_sent++;
            in_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid = 1'b0;
        end else if (in_taken || !i_in_valid) begin
            in_taken = 1'b0;
            if (request_q.size() > 0 &&
                !((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 65) ||
                  (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 32))) begin
                i_in_item  = request_q.pop_front();
                i_in_valid = 1'b1;
            end else begin
                i_in_valid = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stalls at random in the stall modes, and checks each item
    // taken against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        case (idle_mode)
            IDLE_RECEIVER: i_out_ready = ($urandom_range(0, 99) >= 65);
            IDLE_BOTH:     i_out_ready = ($urandom_range(0, 99) >= 32);
            default:       i_out_ready = 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        t_out_item want;
        string     bad;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (result_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result item %p", o_out_item);
            end else begin
                want = result_q.pop_front();
                if (want.used_fallback) fallback_seen++;
                if (!want.accepted) refused_seen++;
                bad = "";
                if (o_out_item.accepted !== want.accepted)           bad = {bad, " accepted"};
                if (o_out_item.pair_out !== want.pair_out)           bad = {bad, " pair_out"};
                if (o_out_item.avg_normal_x !== want.avg_normal_x)   bad = {bad, " normal_x"};
                if (o_out_item.avg_normal_y !== want.avg_normal_y)   bad = {bad, " normal_y"};
                if (o_out_item.avg_normal_z !== want.avg_normal_z)   bad = {bad, " normal_z"};
                if (o_out_item.avg_point_a_x !== want.avg_point_a_x) bad = {bad, " point_a_x"};
                if (o_out_item.avg_point_a_y !== want.avg_point_a_y) bad = {bad, " point_a_y"};
                if (o_out_item.avg_point_a_z !== want.avg_point_a_z) bad = {bad, " point_a_z"};
                if (o_out_item.avg_point_b_x !== want.avg_point_b_x) bad = {bad, " point_b_x"};
                if (o_out_item.avg_point_b_y !== want.avg_point_b_y) bad = {bad, " point_b_y"};
                if (o_out_item.avg_point_b_z !== want.avg_point_b_z) bad = {bad, " point_b_z"};
                if (o_out_item.used_fallback !== want.used_fallback) bad = {bad, " fallback"};
                if (bad != "") begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("ERROR: result %0d differs in%s", results_seen, bad);
                        $display("  expected %p", want);
                        $display("  actual   %p", o_out_item);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles with work outstanding but no item moving.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles = 0;
        end else if (request_q.size() > 0 || i_in_valid || result_q.size() > 0) begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG) begin
                $display("Watchdog expired with %0d results outstanding", result_q.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus. Each batch is loaded into the request queue and drained
    // before the next one starts, so idling modes switch with the block idle.
    // ------------------------------------------------------------------------
    task automatic drain_batch();
        wait (request_q.size() == 0 && !i_in_valid && result_q.size() == 0);
        @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] k0;
        t_in_item    r;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_item      = '0;
        i_out_ready    = 1'b0;
        in_taken       = 1'b0;
        idle_mode      = IDLE_NONE;
        mismatch_count = 0;
        requests_sent  = 0;
        results_seen   = 0;
        fallback_seen  = 0;
        refused_seen   = 0;
        stall_cycles   = 0;
        pair_count     = 0;
        for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = 64'hFFFF_FFFF_0000_0000;
        key_pool[1] = 64'h1234_5678_1234_5678;   // both entity words equal
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: field extremes, swapped matches, a zero normal that
        // falls back to straight up, out-of-range reads, an unused code and a clear.
        k0 = key_pool[0];
        r = make_request(REQ_READ, k0, 5'd0);
        request_q.push_back(r);                       // read of an empty table
        r = make_request(REQ_ADD, k0, 5'd31);
        {r.normal_x, r.normal_y, r.normal_z} = {3{32'sh7FFF_FFFF}};
        {r.point_a_x, r.point_a_y, r.point_a_z} = {3{32'sh7FFF_FFFF}};
        {r.point_b_x, r.point_b_y, r.point_b_z} = {3{32'sh8000_0000}};
        request_q.push_back(r);
        r = make_request(REQ_ADD, {k0[31:0], k0[63:32]}, 5'd0);
        {r.normal_x, r.normal_y, r.normal_z} = {3{32'sh8000_0000}};
        {r.point_a_x, r.point_a_y, r.point_a_z} = {3{32'sh8000_0000}};
        {r.point_b_x, r.point_b_y, r.point_b_z} = {3{32'sh7FFF_FFFF}};
        request_q.push_back(r);
        request_q.push_back(make_request(REQ_READ, k0, 5'd0));
        r = make_request(REQ_ADD, key_pool[1], 5'd0);
        {r.normal_x, r.normal_y, r.normal_z} = '0;
        request_q.push_back(r);
        request_q.push_back(make_request(REQ_READ, k0, 5'd1));
        r = make_request(REQ_ADD, key_pool[2], 5'd0);
        {r.normal_x, r.normal_y, r.normal_z} = {32'sd1, 32'sd0, -32'sd1};
        request_q.push_back(r);
        request_q.push_back(make_request(REQ_READ, k0, 5'd2));
        request_q.push_back(make_request(REQ_READ, k0, 5'd3));
        request_q.push_back(make_request(REQ_READ, k0, 5'd31));
        request_q.push_back(make_request(REQ_UNUSED, k0, 5'd0));
        request_q.push_back(make_request(REQ_CLEAR, k0, 5'd0));
        request_q.push_back(make_request(REQ_READ, k0, 5'd0));
        drain_batch();

        // Fill the table, try one pair too many, then read the last slot and one past it.
        for (int i = 0; i <= TABLE_SLOTS; i++)
            request_q.push_back(make_request(REQ_ADD, {$urandom, 32'(i)}, 5'd0));
        request_q.push_back(make_request(REQ_READ, k0, 5'(TABLE_SLOTS - 1)));
        request_q.push_back(make_request(REQ_READ, k0, 5'(TABLE_SLOTS)));
        drain_batch();

        // Random part, one batch per idling mode.
        for (int m = 0; m < 4; m++) begin
            idle_mode = t_idle_mode'(m);
            for (int i = 0; i < 185; i++) request_q.push_back(make_random_request());
            drain_batch();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Sent %0d requests and checked %0d results (%0d refused, %0d fallbacks),",
                 requests_sent, results_seen, refused_seen, fallback_seen);
        $display("covering field extremes, table fill and all four idling modes.");
        if (mismatch_count == 0 && result_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count, result_q.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
